FILE: sv/srsn_pkg.sv
// Shared types and constants for the slot range splitting node map.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package srsn_pkg;

   localparam int ADDR_W  = 32;
   localparam int PORT_W  = 16;
   localparam int SLOT_W  = 6;
   localparam int NODE_W  = 6;
   localparam int END_W   = 7;
   localparam int STAT_W  = 2;

   localparam logic MODE_ADD    = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_REFUSED = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY   = 2'd2;

   typedef struct packed {
      logic              mode;
      logic [ADDR_W-1:0] node_addr;
      logic [PORT_W-1:0] node_port;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [NODE_W-1:0] node_index;
      logic [ADDR_W-1:0] owner_addr;
      logic [PORT_W-1:0] owner_port;
      logic [SLOT_W-1:0] range_start;
      logic [END_W-1:0]  range_end;
   } rsp_type;

endpackage

`default_nettype wire

FILE: sv/slot_range_splitting_node_map.sv
// Top level of the slot range splitting node map; depends on srsn_pkg and srsn_ram.
// Add refused at the cap and lookup with no nodes answer from idle; a first add
//   fills every slot; a later add walks the runs, then hands over half the longest
//   run (refused if none has two slots); lookup reduces the slot modulo NUM_SLOTS,
//   then walks the runs up to it. One beat at a time; results never stall.
// Reset clears only the sequencer, node count and valid flag; tables are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module slot_range_splitting_node_map #(
   parameter int NUM_SLOTS = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire srsn_pkg::req_type req_item,
   output logic                 rsp_valid,
   output srsn_pkg::rsp_type    rsp_item
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int EW = $clog2(NUM_SLOTS + 1);
   localparam int CW = ((EW > srsn_pkg::SLOT_W) ? EW : srsn_pkg::SLOT_W) + 1;
   localparam int NW = EW + srsn_pkg::ADDR_W + srsn_pkg::PORT_W;
   localparam logic [EW-1:0] N_E = EW'(NUM_SLOTS);
   localparam logic [CW-1:0] N_C = CW'(NUM_SLOTS);
   localparam logic [EW-1:0] TWO = EW'(2);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_MOD       = 4'd1;
   localparam logic [3:0] ST_FILL0     = 4'd2;
   localparam logic [3:0] ST_WALK_OWN  = 4'd3;
   localparam logic [3:0] ST_WALK_NODE = 4'd4;
   localparam logic [3:0] ST_WALK_EVAL = 4'd5;
   localparam logic [3:0] ST_SPLIT     = 4'd6;
   localparam logic [3:0] ST_LK_OWN    = 4'd7;
   localparam logic [3:0] ST_LK_NODE   = 4'd8;
   localparam logic [3:0] ST_LK_DONE   = 4'd9;

   // control
   logic [3:0]    state_ff, state_in;
   logic [EW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   // data
   logic                        mode_ff, mode_in;
   logic [srsn_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [srsn_pkg::PORT_W-1:0] port_ff, port_in;
   logic [srsn_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [EW-1:0]               pos_ff, pos_in;
   logic [EW-1:0]               best_start_ff, best_start_in;
   logic [EW-1:0]               best_len_ff, best_len_in;
   logic [EW-1:0]               fill_ff, fill_in;
   logic [EW-1:0]               split_end_ff, split_end_in;
   logic [EW-1:0]               rs_ff, rs_in;
   logic [EW-1:0]               re_ff, re_in;
   logic [SW-1:0]               owner_ff, owner_in;
   srsn_pkg::rsp_type           rsp_ff, rsp_in;

   // RAM ports
   logic          own_we;
   logic [SW-1:0] own_waddr, own_raddr, own_rdata;
   logic          node_we;
   logic [SW-1:0] node_waddr;
   logic [NW-1:0] node_wdata, node_rdata;

   logic [EW-1:0]               node_end;
   logic [srsn_pkg::ADDR_W-1:0] node_addr;
   logic [srsn_pkg::PORT_W-1:0] node_port;
   logic [EW-1:0]               run_len, len_new, start_new, half;
   logic                        run_bad, walk_done;

   assign node_end  = node_rdata[NW-1 -: EW];
   assign node_addr = node_rdata[srsn_pkg::ADDR_W + srsn_pkg::PORT_W - 1 : srsn_pkg::PORT_W];
   assign node_port = node_rdata[srsn_pkg::PORT_W-1:0];

   assign run_bad   = (node_end <= pos_ff) || (node_end > N_E);
   assign run_len   = node_end - pos_ff;
   assign len_new   = (!run_bad && (run_len > best_len_ff)) ? run_len : best_len_ff;
   assign start_new = (!run_bad && (run_len > best_len_ff)) ? pos_ff : best_start_ff;
   assign walk_done = run_bad || (node_end >= N_E);
   assign half      = len_new >> 1;

   assign own_raddr  = (state_ff == ST_LK_OWN) ? SW'(slot_ff) : pos_ff[SW-1:0];
   assign own_waddr  = fill_ff[SW-1:0];
   assign node_wdata = {((state_ff == ST_FILL0) ? N_E : split_end_ff), addr_ff, port_ff};
   assign node_waddr = (state_ff == ST_FILL0) ? SW'(0) : count_ff[SW-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      mode_in       = mode_ff;
      addr_in       = addr_ff;
      port_in       = port_ff;
      slot_in       = slot_ff;
      pos_in        = pos_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      fill_in       = fill_ff;
      split_end_in  = split_end_ff;
      rs_in         = rs_ff;
      re_in         = re_ff;
      owner_in      = owner_ff;
      rsp_in        = rsp_ff;
      own_we        = 1'b0;
      node_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in       = req_item.mode;
               addr_in       = req_item.node_addr;
               port_in       = req_item.node_port;
               slot_in       = req_item.slot_index;
               pos_in        = '0;
               best_start_in = '0;
               best_len_in   = '0;
               fill_in       = '0;
               rs_in         = '0;
               re_in         = '0;
               if (req_item.mode == srsn_pkg::MODE_ADD) begin
                  if (count_ff >= N_E) begin
                     rsp_in       = '0;
                     rsp_in.status = srsn_pkg::STATUS_REFUSED;
                     rsp_valid_in = 1'b1;
                  end else if (count_ff == '0) begin
                     state_in = ST_FILL0;
                  end else begin
                     state_in = ST_WALK_OWN;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_in        = '0;
                     rsp_in.status = srsn_pkg::STATUS_EMPTY;
                     rsp_valid_in  = 1'b1;
                  end else begin
                     state_in = ST_MOD;
                  end
               end
            end
         end
         ST_MOD: begin
            if (CW'(slot_ff) >= N_C) begin
               slot_in = srsn_pkg::SLOT_W'(CW'(slot_ff) - N_C);
            end else begin
               state_in = ST_WALK_OWN;
            end
         end
         ST_FILL0: begin
            own_we  = 1'b1;
            fill_in = fill_ff + EW'(1);
            if (fill_ff == N_E - EW'(1)) begin
               node_we             = 1'b1;
               count_in            = EW'(1);
               rsp_in.status       = srsn_pkg::STATUS_OK;
               rsp_in.node_index   = '0;
               rsp_in.owner_addr   = addr_ff;
               rsp_in.owner_port   = port_ff;
               rsp_in.range_start  = '0;
               rsp_in.range_end    = srsn_pkg::END_W'(N_E);
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         ST_WALK_OWN: begin
            state_in = ST_WALK_NODE;
         end
         ST_WALK_NODE: begin
            state_in = ST_WALK_EVAL;
         end
         ST_WALK_EVAL: begin
            if (mode_ff == srsn_pkg::MODE_ADD) begin
               best_len_in   = len_new;
               best_start_in = start_new;
               pos_in        = node_end;
               if (walk_done) begin
                  if (len_new < TWO) begin
                     rsp_in        = '0;
                     rsp_in.status = srsn_pkg::STATUS_REFUSED;
                     rsp_valid_in  = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     fill_in      = start_new;
                     split_end_in = start_new + half;
                     state_in     = ST_SPLIT;
                  end
               end else begin
                  state_in = ST_WALK_OWN;
               end
            end else begin
               if (run_bad) begin
                  state_in = ST_LK_OWN;
               end else if (CW'(slot_ff) < CW'(node_end)) begin
                  rs_in    = pos_ff;
                  re_in    = node_end;
                  state_in = ST_LK_OWN;
               end else begin
                  pos_in   = node_end;
                  state_in = walk_done ? ST_LK_OWN : ST_WALK_OWN;
               end
            end
         end
         ST_SPLIT: begin
            own_we  = 1'b1;
            fill_in = fill_ff + EW'(1);
            if (fill_ff + EW'(1) == split_end_ff) begin
               node_we             = 1'b1;
               count_in            = count_ff + EW'(1);
               rsp_in.status       = srsn_pkg::STATUS_OK;
               rsp_in.node_index   = srsn_pkg::NODE_W'(count_ff);
               rsp_in.owner_addr   = addr_ff;
               rsp_in.owner_port   = port_ff;
               rsp_in.range_start  = srsn_pkg::SLOT_W'(best_start_ff);
               rsp_in.range_end    = srsn_pkg::END_W'(split_end_ff);
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         ST_LK_OWN: begin
            state_in = ST_LK_NODE;
         end
         ST_LK_NODE: begin
            owner_in = own_rdata;
            state_in = ST_LK_DONE;
         end
         ST_LK_DONE: begin
            rsp_in.status      = srsn_pkg::STATUS_OK;
            rsp_in.node_index  = srsn_pkg::NODE_W'(owner_ff);
            rsp_in.owner_addr  = node_addr;
            rsp_in.owner_port  = node_port;
            rsp_in.range_start = srsn_pkg::SLOT_W'(rs_ff);
            rsp_in.range_end   = srsn_pkg::END_W'(re_ff);
            rsp_valid_in       = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      addr_ff       <= addr_in;
      port_ff       <= port_in;
      slot_ff       <= slot_in;
      pos_ff        <= pos_in;
      best_start_ff <= best_start_in;
      best_len_ff   <= best_len_in;
      fill_ff       <= fill_in;
      split_end_ff  <= split_end_in;
      rs_ff         <= rs_in;
      re_ff         <= re_in;
      owner_ff      <= owner_in;
      rsp_ff        <= rsp_in;
   end

   srsn_ram #(
      .WIDTH (SW),
      .DEPTH (NUM_SLOTS)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (own_waddr),
      .wr_data ((state_ff == ST_FILL0) ? SW'(0) : count_ff[SW-1:0]),
      .rd_addr (own_raddr),
      .rd_data (own_rdata)
   );

   srsn_ram #(
      .WIDTH (NW),
      .DEPTH (NUM_SLOTS)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wdata),
      .rd_addr (own_rdata),
      .rd_data (node_rdata)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= N_E)
      else $error("node count above slot count");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted beat neither in work nor answered");

   a_walk_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_OWN) |-> (pos_ff < N_E))
      else $error("walk position past table");

   a_split_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPLIT) |-> (fill_ff < split_end_ff))
      else $error("split fill past split point");
`endif

endmodule

`default_nettype wire

FILE: sv/srsn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module srsn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
